/* sv/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* sv/bwph_pkg.sv */
// Package for the binary window pattern histogram: types, constants.
// No dependencies.
package bwph_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_GRAM   = 3;
	localparam int KEY_W      = MAX_GRAM * MAX_GRAM;
	localparam int NBINS      = 1 << KEY_W;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int CNT_W      = 21;
	localparam int CFG_W      = 11;
	localparam int QDEPTH     = 4;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_GRAM   = 2'd2;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic action;
		logic pixel;
	} in_item_t;

	typedef struct packed {
		logic [8:0]       pattern;
		logic [CNT_W-1:0] occurrences;
		logic             last;
	} out_item_t;

	// command from the front part to the histogram engine
	typedef struct packed {
		logic             is_read;
		logic             count;
		logic [KEY_W-1:0] key;
	} cmd_t;
endpackage

/* sv/binary_window_pattern_histogram.sv */
// Top level of the binary window pattern histogram.
// Depends on bwph_pkg, bwph_front, bwph_back.
//
//  channel  | handshake      | payload
//  input    | push / full    | in_data  (in_item_t)
//  result   | pop / empty    | out_data (out_item_t)
//  config   | cfg_we         | cfg_index, cfg_data
//
// A transaction is accepted in any cycle with full low; a counted window reads
// its bin when dequeued and writes it back in the increment state, before the
// next dequeue. A readout scans one bin per cycle.
// After reset a pass over all 512 bins zeroes them; commands wait in the queue.
// full rises once two commands wait; a held result stalls further readouts.
module binary_window_pattern_histogram import bwph_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  in_item_t         in_data,
	output logic             empty,
	input  logic             pop,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	logic [CFG_W-1:0] width_q, height_q;
	logic [1:0]       gram_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(1024);
			height_q <= CFG_W'(1024);
			gram_q <= 2'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_GRAM:   gram_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic cmd_valid, q_afull, res_valid;
	cmd_t cmd;
	assign full = q_afull;
	assign empty = !res_valid;

	bwph_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(push && !full), .in_item(in_data),
		.width_cfg(width_q), .height_cfg(height_q), .gram_cfg(gram_q),
		.cmd_valid(cmd_valid), .cmd(cmd)
	);

	bwph_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.q_afull(q_afull), .res_valid(res_valid), .res(out_data), .res_pop(pop && !empty)
	);
endmodule

/* sv/bwph_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bwph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

/* sv/bwph_front.sv */
// Front part: raster position, line store, window register; issues commands.
// Depends on bwph_pkg and bwph_ram.
module bwph_front import bwph_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  in_item_t         in_item,
	input  logic [CFG_W-1:0] width_cfg,
	input  logic [CFG_W-1:0] height_cfg,
	input  logic [1:0]       gram_cfg,
	output logic             cmd_valid,
	output cmd_t             cmd
);
	// stage 0: position and line-store read
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W:0]   w_eff;
	logic [ROW_W:0]   h_eff;
	logic [1:0]       n_eff;
	logic [COL_W-1:0] col_c, col_nx;
	logic [ROW_W-1:0] row_c, row_nx;
	logic [ROW_W:0]   row_t;

	always_comb begin
		w_eff = (width_cfg == '0) ? (COL_W+1)'(1) :
			(width_cfg > CFG_W'(MAX_WIDTH)) ? (COL_W+1)'(MAX_WIDTH) : width_cfg[COL_W:0];
		h_eff = (height_cfg == '0) ? (ROW_W+1)'(1) :
			(height_cfg > CFG_W'(MAX_HEIGHT)) ? (ROW_W+1)'(MAX_HEIGHT) : height_cfg[ROW_W:0];
		n_eff = (gram_cfg == 2'd0) ? 2'd1 : gram_cfg;
		col_c = col_q;
		row_t = {1'b0, row_q};
		if ({1'b0, col_q} >= w_eff) begin
			col_c = '0;
			row_t = row_t + 1'b1;
		end
		if (row_t >= h_eff)
			row_t = '0;
		row_c = row_t[ROW_W-1:0];
		col_nx = col_c + 1'b1;
		row_nx = row_c;
		if ({1'b0, col_c} + 1'b1 >= w_eff) begin
			col_nx = '0;
			row_t = {1'b0, row_c} + 1'b1;
			row_nx = (row_t >= h_eff) ? '0 : row_t[ROW_W-1:0];
		end
	end

	logic             v_s1, px_s1, rd_s1, win_s1;
	logic [COL_W-1:0] col_s1;
	logic [1:0]       n_s1;
	logic [MAX_GRAM-1:0] rdata;

	// line store: read in stage 0, written in stage 1; bypass same column
	logic [COL_W:0]   fill_cnt_q;
	logic [MAX_GRAM-1:0] word_s1, wr_word_q;
	logic [COL_W-1:0] wr_col_q;
	logic             wr_v_q;

	bwph_ram #(.WIDTH(MAX_GRAM), .DEPTH(MAX_WIDTH)) u_line (
		.clk(clk), .we(v_s1), .waddr(col_s1), .wdata(word_s1),
		.raddr(col_c), .rdata(rdata)
	);

	// fill_cnt marks columns written since reset; others read as zero
	logic [MAX_GRAM-1:0] old_word, mask;
	always_comb begin
		old_word = ({1'b0, col_s1} < fill_cnt_q) ? rdata : '0;
		if (wr_v_q && wr_col_q == col_s1)
			old_word = wr_word_q;
		mask = MAX_GRAM'((1 << n_s1) - 1);
		word_s1 = {old_word[MAX_GRAM-2:0], px_s1} & mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1 <= 1'b0;
			rd_s1 <= 1'b0;
			fill_cnt_q <= '0;
			wr_v_q <= 1'b0;
		end else begin
			v_s1 <= in_valid && in_item.action == ACT_PUSH;
			rd_s1 <= in_valid && in_item.action == ACT_READ;
			wr_v_q <= v_s1;
			if (in_valid && in_item.action == ACT_PUSH) begin
				col_q <= col_nx;
				row_q <= row_nx;
			end
			if (v_s1 && {1'b0, col_s1} == fill_cnt_q && fill_cnt_q != (COL_W+1)'(MAX_WIDTH))
				fill_cnt_q <= fill_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= col_c;
		px_s1 <= in_item.pixel;
		n_s1 <= n_eff;
		win_s1 <= ({1'b0, row_c} + 1'b1 >= (ROW_W+1)'(n_eff)) &&
			({1'b0, col_c} + 1'b1 >= (COL_W+1)'(n_eff));
		wr_word_q <= word_s1;
		wr_col_q <= col_s1;
	end

	// window register and command issue
	logic [KEY_W-1:0] win_q, win_nx;
	always_comb begin
		unique case (n_s1)
			2'd3:    win_nx = {win_q[KEY_W-4:0], word_s1};
			2'd2:    win_nx = KEY_W'({win_q[1:0], word_s1[1:0]});
			default: win_nx = KEY_W'(word_s1[0]);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else begin
			if (v_s1)
				win_q <= win_nx;
		end
	end

	assign cmd_valid   = v_s1 | rd_s1;
	assign cmd.is_read = rd_s1;
	assign cmd.count   = v_s1 & win_s1;
	assign cmd.key     = win_nx;
endmodule

/* sv/bwph_back.sv */
// Back part: command queue, histogram bins, readout scan.
// Depends on bwph_pkg and bwph_ram.
module bwph_back import bwph_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      q_afull,
	output logic      res_valid,
	output out_item_t res,
	input  logic      res_pop
);
	localparam int QA = $clog2(QDEPTH);
	localparam logic [2:0] ST_CLR = 3'd0, ST_IDLE = 3'd1, ST_INC = 3'd2,
		ST_SCAN = 3'd3, ST_OUT = 3'd4;

	// command queue
	cmd_t           q_mem_q [QDEPTH];
	logic [QA-1:0]  wp_q, rp_q;
	logic [QA:0]    cnt_q;
	logic           deq;
	cmd_t           head;
	assign head = q_mem_q[rp_q];
	assign q_afull = cnt_q >= (QA+1)'(QDEPTH - 2);

	always_ff @(posedge clk) begin
		if (cmd_valid)
			q_mem_q[wp_q] <= cmd;
	end

	// bin memory, zeroed by one pass over all bins after reset
	logic [2:0]       st_q;
	logic             we;
	logic [KEY_W-1:0] waddr, raddr, clr_q, key_q, ptr_q, p_q, chk_a_s1;
	logic [CNT_W-1:0] wdata, rdata, p_cnt_q;
	logic [KEY_W:0]   scan_q;
	logic             chk_v_s1, found_q, hit;
	out_item_t        res_q, fnd_q;
	logic             res_v_q;

	bwph_ram #(.WIDTH(CNT_W), .DEPTH(NBINS)) u_bins (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// read data of the bin addressed in the previous scan cycle
	assign hit = chk_v_s1 && rdata != '0;

	always_comb begin
		we = 1'b0;
		waddr = key_q;
		wdata = '0;
		raddr = key_q;
		deq = 1'b0;
		unique case (st_q)
			ST_CLR: begin
				we = 1'b1;
				waddr = clr_q;
			end
			ST_IDLE: begin
				raddr = head.key;
				deq = cnt_q != '0;
			end
			ST_INC: begin
				we = 1'b1;
				wdata = (rdata == CNT_MAX) ? rdata : rdata + 1'b1;
			end
			ST_SCAN: begin
				raddr = scan_q[KEY_W-1:0];
				// first nonzero bin is cleared as it is taken
				if (hit && !found_q) begin
					we = 1'b1;
					waddr = chk_a_s1;
				end
			end
			default: ;
		endcase
	end

	// queue pointers and state machine; the scan issues one bin read per cycle and checks it in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			st_q <= ST_CLR;
			clr_q <= '0;
			key_q <= '0;
			ptr_q <= '0;
			p_q <= '0;
			p_cnt_q <= '0;
			scan_q <= '0;
			chk_v_s1 <= 1'b0;
			chk_a_s1 <= '0;
			found_q <= 1'b0;
			fnd_q <= '0;
			res_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (cmd_valid)
				wp_q <= wp_q + 1'b1;
			if (deq)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QA+1)'(cmd_valid) - (QA+1)'(deq);
			if (st_q == ST_OUT && (!res_v_q || res_pop))
				res_v_q <= 1'b1;
			else if (res_pop)
				res_v_q <= 1'b0;
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1)
						st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (deq) begin
						key_q <= head.key;
						if (head.is_read) begin
							scan_q <= {1'b0, ptr_q};
							chk_v_s1 <= 1'b0;
							found_q <= 1'b0;
							st_q <= ST_SCAN;
						end else if (head.count)
							st_q <= ST_INC;
					end
				end
				ST_INC: st_q <= ST_IDLE;
				ST_SCAN: begin
					if (!scan_q[KEY_W])
						scan_q <= scan_q + 1'b1;
					chk_v_s1 <= !scan_q[KEY_W];
					chk_a_s1 <= scan_q[KEY_W-1:0];
					if (hit && !found_q) begin
						found_q <= 1'b1;
						p_q <= chk_a_s1;
						p_cnt_q <= rdata;
					end else if (hit) begin
						// a later nonzero bin exists
						fnd_q <= '{pattern: 9'(p_q), occurrences: p_cnt_q, last: 1'b0};
						ptr_q <= chk_a_s1;
						st_q <= ST_OUT;
					end else if (!chk_v_s1 && scan_q[KEY_W]) begin
						// end of bins reached
						if (found_q)
							fnd_q <= '{pattern: 9'(p_q), occurrences: p_cnt_q, last: 1'b1};
						else
							fnd_q <= '{pattern: '0, occurrences: '0, last: 1'b1};
						ptr_q <= '0;
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_v_q || res_pop) begin
						res_q <= fnd_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_v_q;
	assign res = res_q;
endmodule

/* sv/bwph_checker.sv */
// Port-level checker for the histogram top level, with its bind.
// Depends on bwph_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bwph_checker import bwph_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      push,
	input logic      full,
	input logic      empty,
	input logic      pop,
	input out_item_t out_data
);
	`ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_data))
	`ASSERT_IMPL(a_empty_zero, clk, arst_n, !empty && out_data.occurrences == '0, out_data.last)
	`ASSERT_IMPL(a_zero_pat, clk, arst_n, !empty && out_data.occurrences == '0, out_data.pattern == '0)
	`ASSERT_IMPL(a_known, clk, arst_n, 1'b1, !$isunknown({push, full, empty, pop}))
endmodule

bind binary_window_pattern_histogram bwph_checker u_checker (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .empty(empty), .pop(pop),
	.out_data(out_data)
);
